@@ rtl/core/vsa_pkg.sv @@
// Shared types, sizes and codes of the versioned snapshot array.
`default_nettype none

package vsa_pkg;

  localparam int NUM_INDICES   = 64;
  localparam int HISTORY_DEPTH = 16;
  localparam int VALUE_WIDTH   = 32;
  localparam int EPOCH_WIDTH   = 16;

  localparam int IDX_W  = (NUM_INDICES > 1) ? $clog2(NUM_INDICES) : 1;
  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int ADDR_W = IDX_W + SLOT_W;
  localparam int WORD_W = EPOCH_WIDTH + VALUE_WIDTH;
  localparam int CMP_W  = (EPOCH_WIDTH > 16) ? EPOCH_WIDTH : 16;

  // Fixed field widths of the stream items.
  localparam int IN_IDX_W  = 6;
  localparam int DATA_W    = 32;
  localparam int SID_W     = 16;
  localparam int LEN_W     = 7;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  localparam logic [LEN_W-1:0]       LEN_RESET = LEN_W'(64);
  localparam logic [EPOCH_WIDTH-1:0] EPOCH_MAX = '1;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_SNAP = 2'd1,
    CMD_GET  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CNT,
    S_SET_CHK,
    S_GET_RD,
    S_GET_CMP,
    S_GET_FIN,
    S_DONE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic decode;
    logic cnt_use;
    logic set_exec;
    logic srch_rd;
    logic srch_cmp;
    logic fin_rd;
    logic fin_use;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_set;
    logic is_get;
    logic oor;
    logic srch_more;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/vsa_ctrl.sv @@
// Sequencing state machine of the versioned snapshot array.
`default_nettype none

module vsa_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire vsa_pkg::dp_sts_t   sts_i,
  output vsa_pkg::ctrl_cmd_t      cmd_o
);

  vsa_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vsa_pkg::S_IDLE: begin
        if (in_valid_i) state_d = vsa_pkg::S_DECODE;
      end
      vsa_pkg::S_DECODE: begin
        if ((sts_i.is_set || sts_i.is_get) && !sts_i.oor) state_d = vsa_pkg::S_CNT;
        else state_d = vsa_pkg::S_DONE;
      end
      vsa_pkg::S_CNT: begin
        if (sts_i.is_set) state_d = vsa_pkg::S_SET_CHK;
        else state_d = vsa_pkg::S_GET_RD;
      end
      vsa_pkg::S_SET_CHK: state_d = vsa_pkg::S_DONE;
      vsa_pkg::S_GET_RD: begin
        if (sts_i.srch_more) state_d = vsa_pkg::S_GET_CMP;
        else state_d = vsa_pkg::S_GET_FIN;
      end
      vsa_pkg::S_GET_CMP: state_d = vsa_pkg::S_GET_RD;
      vsa_pkg::S_GET_FIN: state_d = vsa_pkg::S_DONE;
      vsa_pkg::S_DONE: begin
        if (sts_i.out_free) state_d = vsa_pkg::S_IDLE;
      end
      default: state_d = vsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      vsa_pkg::S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      vsa_pkg::S_DECODE:  cmd_o.decode   = 1'b1;
      vsa_pkg::S_CNT:     cmd_o.cnt_use  = 1'b1;
      vsa_pkg::S_SET_CHK: cmd_o.set_exec = 1'b1;
      vsa_pkg::S_GET_RD: begin
        cmd_o.srch_rd = sts_i.srch_more;
        cmd_o.fin_rd  = !sts_i.srch_more;
      end
      vsa_pkg::S_GET_CMP: cmd_o.srch_cmp = 1'b1;
      vsa_pkg::S_GET_FIN: cmd_o.fin_use  = 1'b1;
      vsa_pkg::S_DONE:    cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/vsa_datapath.sv @@
// History memories, epoch counter, search bounds and result registers.
`default_nettype none

module vsa_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire vsa_pkg::ctrl_cmd_t                   cmd_i,
  output vsa_pkg::dp_sts_t                          sts_o,
  input  wire logic                                 cfg_valid_i,
  input  wire logic [vsa_pkg::LEN_W-1:0]            cfg_data_i,
  input  wire logic [1:0]                           in_command_i,
  input  wire logic [vsa_pkg::IN_IDX_W-1:0]         in_index_i,
  input  wire logic signed [vsa_pkg::DATA_W-1:0]    in_write_value_i,
  input  wire logic [vsa_pkg::SID_W-1:0]            in_snapshot_id_i,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output logic signed [vsa_pkg::DATA_W-1:0]         out_read_value_o,
  output logic [vsa_pkg::SID_W-1:0]                 out_taken_id_o,
  output vsa_pkg::status_e                          out_status_o
);

  localparam int IDX_W  = vsa_pkg::IDX_W;
  localparam int SLOT_W = vsa_pkg::SLOT_W;
  localparam int CNT_W  = vsa_pkg::CNT_W;
  localparam int ADDR_W = vsa_pkg::ADDR_W;
  localparam int WORD_W = vsa_pkg::WORD_W;
  localparam int EW     = vsa_pkg::EPOCH_WIDTH;
  localparam int VW     = vsa_pkg::VALUE_WIDTH;
  localparam int CMP_W  = vsa_pkg::CMP_W;

  // Item registers.
  vsa_pkg::cmd_e                       cmd_q;
  logic [vsa_pkg::IN_IDX_W-1:0]        idx_q;
  logic signed [vsa_pkg::DATA_W-1:0]   wval_q;
  logic [vsa_pkg::SID_W-1:0]           sid_q;

  logic [vsa_pkg::LEN_W-1:0] act_len_q;
  logic [EW-1:0]             epoch_q;

  // History store: id in the upper bits, value in the lower bits.
  logic [WORD_W-1:0] hist_mem [2**ADDR_W];
  logic [WORD_W-1:0] hist_rdata_q;
  logic              rd_zero_q;
  logic [CNT_W-1:0]  cnt_mem [2**IDX_W];
  logic [CNT_W-1:0]  cnt_rdata_q;

  // Entry zero of each cell and each count read as their reset value until written.
  logic [vsa_pkg::NUM_INDICES-1:0] e0_vld_q;
  logic [vsa_pkg::NUM_INDICES-1:0] cnt_vld_q;

  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] lo_q, hi_q;

  logic signed [vsa_pkg::DATA_W-1:0] res_value_q;
  logic [vsa_pkg::SID_W-1:0]         res_tid_q;
  vsa_pkg::status_e                  res_st_q;
  logic                              out_valid_q;

  logic [IDX_W-1:0]  idx_m;
  logic              oor;
  logic [CNT_W-1:0]  cnt_eff;
  logic [CNT_W:0]    lohi_sum;
  logic [CNT_W-1:0]  mid;
  logic [SLOT_W-1:0] rd_slot;
  logic [ADDR_W-1:0] hist_raddr;
  logic [EW-1:0]     id_eff;
  logic [VW-1:0]     val_eff;
  logic [VW-1:0]     store_val;
  logic              hist_we;
  logic [ADDR_W-1:0] hist_waddr;
  logic [WORD_W-1:0] hist_wdata;
  logic              cnt_we;
  logic [CNT_W-1:0]  cnt_wdata;
  logic              e0_set;
  logic              is_overwrite;
  logic              is_full;
  logic [CNT_W-1:0]  last_slot;

  assign idx_m     = IDX_W'(idx_q);
  assign oor       = ({1'b0, idx_q} >= act_len_q) || (int'(idx_q) >= vsa_pkg::NUM_INDICES);
  assign cnt_eff   = cnt_vld_q[idx_m] ? cnt_rdata_q : CNT_W'(1);
  assign lohi_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = lohi_sum[CNT_W:1];
  assign id_eff    = rd_zero_q ? '0 : hist_rdata_q[WORD_W-1 -: EW];
  assign val_eff   = rd_zero_q ? '0 : hist_rdata_q[VW-1:0];
  assign store_val = VW'(wval_q);
  assign last_slot = cnt_q - CNT_W'(1);
  assign is_overwrite = (id_eff == epoch_q);
  assign is_full      = (cnt_q == CNT_W'(vsa_pkg::HISTORY_DEPTH));

  always_comb begin
    rd_slot = '0;
    if (cmd_i.cnt_use) begin
      rd_slot = SLOT_W'(cnt_eff - CNT_W'(1));
    end else if (cmd_i.srch_rd) begin
      rd_slot = SLOT_W'(mid);
    end else if (cmd_i.fin_rd) begin
      rd_slot = (lo_q == '0) ? '0 : SLOT_W'(lo_q - CNT_W'(1));
    end
  end
  assign hist_raddr = {idx_m, rd_slot};

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = {idx_m, SLOT_W'(last_slot)};
    hist_wdata = {epoch_q, store_val};
    cnt_we     = 1'b0;
    cnt_wdata  = cnt_q + CNT_W'(1);
    e0_set     = 1'b0;
    if (cmd_i.set_exec) begin
      if (is_overwrite) begin
        hist_we = 1'b1;
        e0_set  = (last_slot == '0);
      end else if (!is_full) begin
        hist_we    = 1'b1;
        hist_waddr = {idx_m, SLOT_W'(cnt_q)};
        cnt_we     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rdata_q <= hist_mem[hist_raddr];
    rd_zero_q    <= (rd_slot == '0) && !e0_vld_q[idx_m];
  end

  // The count port reads the current cell every cycle.
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[idx_m] <= cnt_wdata;
    cnt_rdata_q <= cnt_mem[idx_m];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_vld_q  <= '0;
      cnt_vld_q <= '0;
    end else begin
      if (e0_set) e0_vld_q[idx_m] <= 1'b1;
      if (cnt_we) cnt_vld_q[idx_m] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q  <= vsa_pkg::cmd_e'(in_command_i);
      idx_q  <= in_index_i;
      wval_q <= in_write_value_i;
      sid_q  <= in_snapshot_id_i;
    end
    if (cmd_i.cnt_use) begin
      cnt_q <= cnt_eff;
      lo_q  <= '0;
      hi_q  <= cnt_eff;
    end
    if (cmd_i.srch_cmp) begin
      if (CMP_W'(id_eff) > CMP_W'(sid_q)) hi_q <= mid;
      else lo_q <= mid + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_len_q <= vsa_pkg::LEN_RESET;
      epoch_q   <= '0;
    end else begin
      if (cfg_valid_i) act_len_q <= cfg_data_i;
      if (cmd_i.decode && (cmd_q == vsa_pkg::CMD_SNAP) && (epoch_q != vsa_pkg::EPOCH_MAX)) begin
        epoch_q <= epoch_q + EW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      res_value_q <= '0;
      res_tid_q   <= '0;
      res_st_q    <= vsa_pkg::ST_OK;
      case (cmd_q) inside
        vsa_pkg::CMD_SNAP: begin
          res_tid_q <= vsa_pkg::SID_W'(epoch_q);
          if (epoch_q == vsa_pkg::EPOCH_MAX) res_st_q <= vsa_pkg::ST_SAT;
        end
        vsa_pkg::CMD_SET, vsa_pkg::CMD_GET: begin
          if (oor) res_st_q <= vsa_pkg::ST_RANGE;
        end
        default: ;
      endcase
    end
    if (cmd_i.set_exec && !is_overwrite && is_full) res_st_q <= vsa_pkg::ST_FULL;
    if (cmd_i.fin_use) res_value_q <= vsa_pkg::DATA_W'($signed(val_eff));
    if (cmd_i.out_load) begin
      out_read_value_o <= res_value_q;
      out_taken_id_o   <= res_tid_q;
      out_status_o     <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.is_set    = (cmd_q == vsa_pkg::CMD_SET);
  assign sts_o.is_get    = (cmd_q == vsa_pkg::CMD_GET);
  assign sts_o.oor       = oor;
  assign sts_o.srch_more = (lo_q < hi_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // The epoch only ever steps up by one.
  a_epoch_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(epoch_q) |-> epoch_q == $past(epoch_q) + EW'(1))
    else $error("epoch changed by other than one");

  // Only an in-range set writes the history.
  a_write_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_we |-> (cmd_q == vsa_pkg::CMD_SET) && !oor)
    else $error("history written outside a set");

  // An append never grows a history past its depth.
  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> (cnt_q < CNT_W'(vsa_pkg::HISTORY_DEPTH)) && (cnt_wdata == cnt_q + CNT_W'(1)))
    else $error("history count overflow");

  // A result is loaded only into a free output register.
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending result");

endmodule

`default_nettype wire

@@ rtl/core/versioned_snapshot_array_core.sv @@
// Top level of the versioned snapshot array: stream ports, controller and datapath.
// Each request is a set, snap or get on one of up to 64 cells; every request yields
// exactly one result. Requests are taken one at a time, and the next one may enter
// while the previous result still waits in the output register. After acceptance a
// request is decoded; snap, an unused command and an index out of range then go to
// the result load, a set reads the count, then the newest pair, and a get reads the
// count and runs k binary-search probes, k at most ceil(log2(count+1)), each a read
// then a compare on the single history read port, then reads the selected pair. The
// result is loaded once the output register is free, and the controller returns to
// idle before it accepts the next request. There is no clearing pass after reset. The
// configuration register (active length) takes a write in every cycle and should be
// written only while no request is in flight.
`default_nettype none

module versioned_snapshot_array_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // index [5:0], write_value [37:6], snapshot_id [53:38], zero pad [55:54]
  input  wire logic [vsa_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // command [1:0]
  input  wire logic [1:0]                          s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // read_value [31:0], taken_id [47:32]
  output logic [vsa_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  // status [1:0]
  output logic [1:0]                               m_axis_tuser,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [vsa_pkg::LEN_W-1:0]           cfg_data_i
);

  vsa_pkg::ctrl_cmd_t                 cmd;
  vsa_pkg::dp_sts_t                   sts;
  logic signed [vsa_pkg::DATA_W-1:0]  read_value;
  logic [vsa_pkg::SID_W-1:0]          taken_id;
  vsa_pkg::status_e                   status;

  assign cfg_ready_o = 1'b1;

  vsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vsa_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .in_command_i     (s_axis_tuser),
    .in_index_i       (s_axis_tdata[5:0]),
    .in_write_value_i (s_axis_tdata[37:6]),
    .in_snapshot_id_i (s_axis_tdata[53:38]),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .out_read_value_o (read_value),
    .out_taken_id_o   (taken_id),
    .out_status_o     (status)
  );

  assign m_axis_tdata = {taken_id, read_value};
  assign m_axis_tuser = status;

endmodule

`default_nettype wire

@@ tb/sv/tb_versioned_snapshot_array_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the versioned snapshot array core.
module tb_versioned_snapshot_array_core;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [vsa_pkg::DATA_W-1:0] read_value;
    logic [vsa_pkg::SID_W-1:0]  taken_id;
    logic [1:0]                 status;
  } reply_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [vsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic [1:0]                      s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [vsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]                      m_axis_tuser;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [vsa_pkg::LEN_W-1:0]       cfg_data_i;

  // Shadow copy of the array state, updated at every accepted request.
  logic [vsa_pkg::EPOCH_WIDTH-1:0]
      cell_ids [vsa_pkg::NUM_INDICES][vsa_pkg::HISTORY_DEPTH];
  logic signed [vsa_pkg::VALUE_WIDTH-1:0]
      cell_vals [vsa_pkg::NUM_INDICES][vsa_pkg::HISTORY_DEPTH];
  int unsigned                     cell_depth[vsa_pkg::NUM_INDICES];
  logic [vsa_pkg::EPOCH_WIDTH-1:0] epoch_now;
  logic [vsa_pkg::LEN_W-1:0]       cells_in_use;

  reply_t      replies_due[$];
  int unsigned mismatch_count;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_hold_cycles;

  versioned_snapshot_array_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void clear_array_shadow();
    for (int c = 0; c < vsa_pkg::NUM_INDICES; c++) begin
      cell_ids[c][0]  = '0;
      cell_vals[c][0] = '0;
      cell_depth[c]   = 1;
    end
    epoch_now    = '0;
    cells_in_use = vsa_pkg::LEN_RESET;
  endfunction

  // Computes the reply of one request and applies its effect to the shadow state.
  function automatic reply_t apply_array_command(input logic [1:0] cmd,
      input logic [vsa_pkg::IN_IDX_W-1:0] idx, input logic [vsa_pkg::DATA_W-1:0] wval,
      input logic [vsa_pkg::SID_W-1:0] sid);
    reply_t                                 r;
    int unsigned                            cnt;
    int unsigned                            lo;
    int unsigned                            hi;
    int unsigned                            mid;
    logic signed [vsa_pkg::VALUE_WIDTH-1:0] kept;
    r = '0;
    case (cmd) inside
      vsa_pkg::CMD_SNAP: begin
        r.taken_id = vsa_pkg::SID_W'(epoch_now);
        if (epoch_now == vsa_pkg::EPOCH_MAX) r.status = vsa_pkg::ST_SAT;
        else epoch_now = epoch_now + 1'b1;
      end
      vsa_pkg::CMD_SET, vsa_pkg::CMD_GET: begin
        if (idx >= cells_in_use || idx >= vsa_pkg::NUM_INDICES) begin
          r.status = vsa_pkg::ST_RANGE;
        end else begin
          cnt = cell_depth[idx];
          if (cmd == vsa_pkg::CMD_SET) begin
            kept = vsa_pkg::VALUE_WIDTH'($signed(wval));
            if (cell_ids[idx][cnt-1] == epoch_now) begin
              cell_vals[idx][cnt-1] = kept;
            end else if (cnt >= vsa_pkg::HISTORY_DEPTH) begin
              r.status = vsa_pkg::ST_FULL;
            end else begin
              cell_ids[idx][cnt]  = epoch_now;
              cell_vals[idx][cnt] = kept;
              cell_depth[idx]     = cnt + 1;
            end
          end else begin
            // Locate the first pair newer than the requested snapshot.
            lo = 0;
            hi = cnt;
            while (lo < hi) begin
              mid = (lo + hi) / 2;
              if (cell_ids[idx][mid] > sid) hi = mid;
              else lo = mid + 1;
            end
            if (lo == 0) lo = 1;
            kept = cell_vals[idx][lo-1];
            r.read_value = vsa_pkg::DATA_W'(kept);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_cycles = rx_hold_cycles - 1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : reply_checker
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        $error("reply with no request outstanding: data %h status %h",
               m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = replies_due.pop_front();
        if (m_axis_tdata[vsa_pkg::DATA_W-1:0] !== want.read_value) begin
          $error("read_value mismatch: expected %h, got %h",
                 want.read_value, m_axis_tdata[vsa_pkg::DATA_W-1:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[vsa_pkg::DATA_W +: vsa_pkg::SID_W] !== want.taken_id) begin
          $error("taken_id mismatch: expected %h, got %h",
                 want.taken_id, m_axis_tdata[vsa_pkg::DATA_W +: vsa_pkg::SID_W]);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status mismatch: expected %h, got %h", want.status, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Entered and left at a falling edge; valid stays high into the next request.
  task automatic send_request(input logic [1:0] cmd,
      input logic [vsa_pkg::IN_IDX_W-1:0] idx, input logic [vsa_pkg::DATA_W-1:0] wval,
      input logic [vsa_pkg::SID_W-1:0] sid);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, sid, wval, idx};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    replies_due.push_back(apply_array_command(cmd, idx, wval, sid));
    @(negedge clk_i);
  endtask

  task automatic wait_all_replies();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (replies_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_active_length(input logic [vsa_pkg::LEN_W-1:0] len);
    wait_all_replies();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cells_in_use = len;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly in-range cells and snapshot ids near the current epoch.
  task automatic send_random_request();
    int unsigned                  pick;
    logic [1:0]                   cmd;
    logic [vsa_pkg::IN_IDX_W-1:0] idx;
    logic [vsa_pkg::SID_W-1:0]    sid;
    pick = $urandom_range(99);
    if (pick < 40) cmd = vsa_pkg::CMD_SET;
    else if (pick < 60) cmd = vsa_pkg::CMD_SNAP;
    else if (pick < 95) cmd = vsa_pkg::CMD_GET;
    else cmd = CMD_UNUSED;
    if (cells_in_use != 0 && $urandom_range(9) != 0)
      idx = vsa_pkg::IN_IDX_W'($urandom_range((cells_in_use > vsa_pkg::NUM_INDICES) ?
                                              vsa_pkg::NUM_INDICES - 1 :
                                              cells_in_use - 1));
    else
      idx = vsa_pkg::IN_IDX_W'($urandom);
    if ($urandom_range(9) < 7) sid = vsa_pkg::SID_W'($urandom_range(int'(epoch_now) + 2));
    else sid = vsa_pkg::SID_W'($urandom);
    send_request(cmd, idx, vsa_pkg::DATA_W'($urandom), sid);
  endtask

  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_request(vsa_pkg::CMD_GET, 6'd0, '0, '0);
    send_request(vsa_pkg::CMD_SET, 6'd63, 32'h7fff_ffff, 16'hffff);
    // Same epoch as the initial pair, so this overwrites it.
    send_request(vsa_pkg::CMD_SET, 6'd63, 32'h8000_0000, '0);
    send_request(vsa_pkg::CMD_GET, 6'd63, '0, '0);
    send_request(vsa_pkg::CMD_SNAP, 6'd63, '0, '0);
    send_request(vsa_pkg::CMD_SET, 6'd63, 32'hffff_ffff, '0);
    send_request(vsa_pkg::CMD_GET, 6'd63, '0, 16'd0);
    send_request(vsa_pkg::CMD_GET, 6'd63, '0, 16'd1);
    send_request(vsa_pkg::CMD_GET, 6'd63, '0, 16'hffff);
    send_request(CMD_UNUSED, 6'h3f, 32'hffff_ffff, 16'hffff);
    send_request(vsa_pkg::CMD_SET, 6'd0, 32'h0000_0001, '0);
    send_request(vsa_pkg::CMD_GET, 6'd0, '0, 16'd0);
    write_active_length(7'd1);
    send_request(vsa_pkg::CMD_SET, 6'd1, 32'h1234_5678, '0);
    send_request(vsa_pkg::CMD_GET, 6'd63, '0, 16'd1);
    send_request(vsa_pkg::CMD_SNAP, 6'd63, 32'hffff_ffff, 16'hffff);
    send_request(vsa_pkg::CMD_GET, 6'd0, '0, 16'd1);
    write_active_length(7'd0);
    send_request(vsa_pkg::CMD_GET, 6'd0, '0, 16'd1);
    send_request(vsa_pkg::CMD_SET, 6'd0, 32'h5555_aaaa, '0);
    send_request(vsa_pkg::CMD_SNAP, 6'd0, '0, '0);
    write_active_length(7'd127);
    send_request(vsa_pkg::CMD_GET, 6'd63, '0, 16'd1);
    wait_all_replies();
  endtask

  // Fills one cell to its full depth, then checks overwrite, drop and search.
  task automatic test_history_full();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (vsa_pkg::HISTORY_DEPTH - 2) begin
      send_request(vsa_pkg::CMD_SET, 6'd5, vsa_pkg::DATA_W'($urandom), '0);
      send_request(vsa_pkg::CMD_SNAP, 6'd5, '0, '0);
    end
    send_request(vsa_pkg::CMD_SET, 6'd5, vsa_pkg::DATA_W'($urandom), '0);
    send_request(vsa_pkg::CMD_SET, 6'd5, vsa_pkg::DATA_W'($urandom), '0);
    send_request(vsa_pkg::CMD_SNAP, 6'd5, '0, '0);
    send_request(vsa_pkg::CMD_SET, 6'd5, vsa_pkg::DATA_W'($urandom), '0);
    for (int s = 0; s < 12; s++)
      send_request(vsa_pkg::CMD_GET, 6'd5, '0,
                   vsa_pkg::SID_W'($urandom_range(int'(epoch_now) + 1)));
    send_request(vsa_pkg::CMD_GET, 6'd5, '0, 16'hffff);
    wait_all_replies();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_active_length(7'd8);
    rx_hold_cycles = 200;
    repeat (30) send_random_request();
    // Let the block run empty before the sender resumes.
    wait_all_replies();
    repeat (10) send_random_request();
    wait_all_replies();
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
      input logic [vsa_pkg::LEN_W-1:0] len_a, input logic [vsa_pkg::LEN_W-1:0] len_b,
      input int unsigned n);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    write_active_length(len_a);
    repeat (n) send_random_request();
    write_active_length(len_b);
    repeat (n) send_random_request();
    wait_all_replies();
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    mismatch_count = 0;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    rx_hold_cycles = 0;
    clear_array_shadow();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_history_full();
    test_backpressure();
    test_random_traffic(6, 48, 7'd3, 7'd64, 270);
    test_random_traffic(48, 6, 7'd1, 7'd127, 270);
    test_random_traffic(0, 0, vsa_pkg::LEN_W'($urandom_range(1, 64)),
                        vsa_pkg::LEN_W'($urandom), 270);

    wait_all_replies();
    // Any stray reply after the last request is flagged by the checker.
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
